// ----- src/pmst_pkg.sv -----
// Shared constants and types of the Prim spanning tree engine.
// Has no dependencies; the interfaces, the top level and the checker use it.
`default_nettype none

package pmst_pkg;

    // Widths of the fields carried on the channels.
    localparam int VID_W    = 5;
    localparam int WEIGHT_W = 15;
    localparam int TOTAL_W  = 20;

    // Vertex ids on the ports are five bits wide, so no run uses more than this.
    localparam int ID_LIMIT         = 32;
    localparam int MAX_VERTICES_DEF = 32;

    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [VID_W-1:0]    t_vid;
    typedef logic [TOTAL_W-1:0]  t_total;

    localparam t_weight NO_EDGE = 15'h7FFF;

    // Operation codes of an input word.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_VERTEX  = 1'd1;

    localparam logic [5:0] NUM_VERTICES_RST = 6'd8;
    localparam logic [4:0] ROOT_VERTEX_RST  = 5'd1;

endpackage

`default_nettype wire

// ----- src/pmst_in_if.sv -----
// Input channel of the spanning tree engine: matrix writes and start commands.
// Depends on pmst_pkg for the field widths.
`default_nettype none

interface pmst_in_if;
    logic              valid;
    logic              ready;
    logic              op;
    pmst_pkg::t_vid    row;
    pmst_pkg::t_vid    col;
    pmst_pkg::t_weight weight;

    modport source (output valid, output op, output row, output col, output weight,
                    input ready);
    modport sink   (input valid, input op, input row, input col, input weight,
                    output ready);
endinterface

`default_nettype wire

// ----- src/pmst_out_if.sv -----
// Output channel of the spanning tree engine: one word per reported vertex.
// Depends on pmst_pkg for the field widths.
`default_nettype none

interface pmst_out_if;
    logic              valid;
    logic              ready;
    pmst_pkg::t_vid    parent;
    pmst_pkg::t_vid    child;
    pmst_pkg::t_weight edge_cost;
    logic              reached;
    pmst_pkg::t_total  run_cost;
    logic              last;

    modport source (output valid, output parent, output child, output edge_cost,
                    output reached, output run_cost, output last, input ready);
    modport sink   (input valid, input parent, input child, input edge_cost,
                    input reached, input run_cost, input last, output ready);
endinterface

`default_nettype wire

// ----- src/prim_minimum_spanning_tree_top.sv -----
// Prim minimum spanning tree engine over a weighted adjacency matrix in block memory.
// Depends on pmst_pkg, pmst_in_if and pmst_out_if.
//
// After reset the weight memory is cleared to no-edge, one entry per cycle, all
// 2**(2*clog2(MAX_VERTICES)) entries (1024 at the default size); no input word is
// taken during that time. A matrix write word is written to the weight memory as
// it is taken. A start word runs one pass over a matrix row per vertex added to the
// tree, each pass reading the n vertices in use; the pass of the last vertex added
// finds nothing left to add and ends the search. The pace is set by the single read
// port of the weight memory, which delivers one row entry per cycle. The n - 1
// result words then leave one at a time, each held until the sink takes it before
// the next is read, and the root is stepped over. The block takes the next input
// word once the last result word of a run has been taken.
`default_nettype none

module prim_minimum_spanning_tree_top #(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pmst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pmst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pmst_in_if.sink                              i_req,
    pmst_out_if.source                           o_rsp
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CAP   = (MAX_VERTICES < pmst_pkg::ID_LIMIT) ? MAX_VERTICES
                                                               : pmst_pkg::ID_LIMIT;
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_RELAX    = 3'd2;
    localparam logic [2:0] S_RP_ISSUE = 3'd3;
    localparam logic [2:0] S_RP_LOAD  = 3'd4;
    localparam logic [2:0] S_RP_WAIT  = 3'd5;

    typedef struct packed {
        logic              in_tree;
        logic [VW-1:0]     parent;
        pmst_pkg::t_weight key;
    } t_vstate;

    // Configuration registers.
    logic [5:0] r_cfg_nv;
    logic [4:0] r_cfg_root;

    // Control.
    logic [2:0]    r_state;
    logic [AW-1:0] r_clr_addr;
    logic [VW-1:0] r_idx;
    logic [VW-1:0] r_nlast;
    logic [VW-1:0] r_root;
    logic [VW-1:0] r_lastv;
    logic [VW-1:0] r_pick;
    logic          r_first;
    logic          r_issue;
    logic          r_s1_valid;
    logic [VW-1:0] r_s1_idx;
    logic          r_s1_last;
    pmst_pkg::t_weight r_low;
    logic [VW-1:0]     r_found;
    logic              r_has;
    pmst_pkg::t_total  r_total;

    // Memories and their registered read data.
    pmst_pkg::t_weight r_wmem [DEPTH];
    pmst_pkg::t_weight r_w_rd;
    t_vstate           r_smem [MAX_VERTICES];
    t_vstate           r_s_rd;

    // Output register.
    logic              r_out_valid;
    pmst_pkg::t_vid    r_out_parent;
    pmst_pkg::t_vid    r_out_child;
    pmst_pkg::t_weight r_out_cost;
    logic              r_out_reached;
    pmst_pkg::t_total  r_out_total;
    logic              r_out_last;

    logic              in_acc;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    pmst_pkg::t_weight w_wdata;
    logic [VW-1:0]     st_nlast;
    logic [VW-1:0]     st_root;
    t_vstate           s1_st;
    t_vstate           s_wdata;
    logic              s_we;
    logic              take;

    assign in_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.parent    = r_out_parent;
    assign o_rsp.child     = r_out_child;
    assign o_rsp.edge_cost = r_out_cost;
    assign o_rsp.reached   = r_out_reached;
    assign o_rsp.run_cost  = r_out_total;
    assign o_rsp.last      = r_out_last;

    // Vertex count and root as used by a run.
    always_comb begin
        int nv;
        int rt;
        nv = int'(r_cfg_nv);
        if (nv < 2) begin
            nv = 2;
        end
        if (nv > CAP) begin
            nv = CAP;
        end
        rt = int'(r_cfg_root);
        if (rt >= nv) begin
            rt = nv - 1;
        end
        st_nlast = VW'(nv - 1);
        st_root  = VW'(rt);
    end

    // Weight memory write port: the clearing sweep, or a matrix write word.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = pmst_pkg::NO_EDGE;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end else if (in_acc && (i_req.op == pmst_pkg::OP_WRITE)
                     && (int'(i_req.row) < MAX_VERTICES)
                     && (int'(i_req.col) < MAX_VERTICES)) begin
            w_we    = 1'b1;
            w_waddr = {VW'(i_req.row), VW'(i_req.col)};
            w_wdata = i_req.weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= w_wdata;
        end
        r_w_rd <= r_wmem[{r_pick, r_idx}];
    end

    // Second stage of a pass: relax one vertex against the vertex just added, and
    // track the lowest key outside the tree for the next pass. The first pass sees
    // the initial per-vertex state instead of the memory.
    always_comb begin
        if (r_first) begin
            s1_st.in_tree = 1'b0;
            s1_st.parent  = '0;
            s1_st.key     = pmst_pkg::NO_EDGE;
        end else begin
            s1_st = r_s_rd;
        end
        s_wdata = s1_st;
        if (r_s1_idx == r_pick) begin
            s_wdata.in_tree = 1'b1;
        end else if (!s1_st.in_tree && (r_w_rd != pmst_pkg::NO_EDGE)
                     && (r_w_rd < s1_st.key)) begin
            s_wdata.key    = r_w_rd;
            s_wdata.parent = r_pick;
        end
        take = r_s1_valid && (r_s1_idx != r_pick) && !s1_st.in_tree
               && (s_wdata.key < r_low);
        s_we = r_s1_valid && (r_state == S_RELAX);
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[r_s1_idx] <= s_wdata;
        end
        r_s_rd <= r_smem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nv <= pmst_pkg::NUM_VERTICES_RST;
            r_cfg_root <= pmst_pkg::ROOT_VERTEX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pmst_pkg::CFG_NUM_VERTICES: r_cfg_nv <= i_cfg_data;
                pmst_pkg::CFG_ROOT_VERTEX:  r_cfg_root <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_issue     <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && (i_req.op == pmst_pkg::OP_START)) begin
                        r_nlast <= st_nlast;
                        r_root  <= st_root;
                        r_lastv <= (st_root == st_nlast) ? st_nlast - 1'b1 : st_nlast;
                        r_pick  <= st_root;
                        r_first <= 1'b1;
                        r_issue <= 1'b1;
                        r_idx   <= '0;
                        r_low   <= pmst_pkg::NO_EDGE;
                        r_has   <= 1'b0;
                        r_total <= '0;
                        r_state <= S_RELAX;
                    end
                end
                S_RELAX: begin
                    // First stage: read the row entry and the vertex state.
                    if (r_issue) begin
                        r_s1_valid <= 1'b1;
                        r_s1_idx   <= r_idx;
                        r_s1_last  <= (r_idx == r_nlast);
                        if (r_idx == r_nlast) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_s1_valid <= 1'b0;
                    end
                    if (r_s1_valid) begin
                        if ((r_s1_idx == r_pick) && !r_first) begin
                            r_total <= r_total + pmst_pkg::TOTAL_W'(s1_st.key);
                        end
                        if (r_s1_last) begin
                            r_first <= 1'b0;
                            r_idx   <= '0;
                            r_low   <= pmst_pkg::NO_EDGE;
                            r_has   <= 1'b0;
                            if (take) begin
                                r_pick  <= r_s1_idx;
                                r_issue <= 1'b1;
                            end else if (r_has) begin
                                r_pick  <= r_found;
                                r_issue <= 1'b1;
                            end else begin
                                r_state <= S_RP_ISSUE;
                            end
                        end else if (take) begin
                            r_low   <= s_wdata.key;
                            r_found <= r_s1_idx;
                            r_has   <= 1'b1;
                        end
                    end
                end
                S_RP_ISSUE: begin
                    r_s1_valid <= 1'b0;
                    if (r_idx == r_root) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_RP_LOAD;
                    end
                end
                S_RP_LOAD: begin
                    r_out_valid   <= 1'b1;
                    r_out_reached <= r_s_rd.in_tree;
                    r_out_parent  <= r_s_rd.in_tree ? pmst_pkg::VID_W'(r_s_rd.parent) : '0;
                    r_out_child   <= pmst_pkg::VID_W'(r_idx);
                    r_out_cost    <= r_s_rd.in_tree ? r_s_rd.key : pmst_pkg::NO_EDGE;
                    r_out_last    <= (r_idx == r_lastv);
                    r_out_total   <= (r_idx == r_lastv) ? r_total : '0;
                    r_state       <= S_RP_WAIT;
                end
                S_RP_WAIT: begin
                    if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RP_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/pmst_checker.sv -----
// Port-level checks of the spanning tree engine, bound to its top level.
// Depends on pmst_pkg and on the ports of prim_minimum_spanning_tree_top.
`default_nettype none

module pmst_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire pmst_pkg::t_vid    i_parent,
    input wire pmst_pkg::t_vid    i_child,
    input wire pmst_pkg::t_weight i_edge_cost,
    input wire logic              i_reached,
    input wire pmst_pkg::t_total  i_run_cost,
    input wire logic              i_last
);

    // A result word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_child)
            && $stable(i_parent) && $stable(i_edge_cost) && $stable(i_last))
        else $error("result word changed while stalled");

    // No new input word is taken while a result word is pending on the output.
    a_no_input_during_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while a result word is pending");

    // An unreached vertex carries no tree edge.
    a_unreached_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_reached |-> (i_edge_cost == pmst_pkg::NO_EDGE)
            && (i_parent == '0))
        else $error("unreached vertex reported with an edge");

    // The total appears on the last word of a run only.
    a_total_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> (i_run_cost == '0))
        else $error("total cost on a word other than the last");

    // A run ends with its last word.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last |=> !i_out_valid)
        else $error("result word after the last word of a run");

endmodule

bind prim_minimum_spanning_tree_top pmst_checker u_pmst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_parent    (o_rsp.parent),
    .i_child     (o_rsp.child),
    .i_edge_cost (o_rsp.edge_cost),
    .i_reached   (o_rsp.reached),
    .i_run_cost  (o_rsp.run_cost),
    .i_last      (o_rsp.last)
);

`default_nettype wire

// ----- verif/prim_minimum_spanning_tree_checker.sv -----
// Scoreboard for the Prim spanning tree engine: mirrors the weight matrix and the
// two registers, predicts the result words of every start word and compares them.
// Depends on pmst_pkg, pmst_in_if and pmst_out_if.
module prim_minimum_spanning_tree_checker #(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pmst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pmst_in_if                              i_req,
    pmst_out_if                             i_rsp,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pmst_pkg::*;

    typedef struct packed {
        t_vid    parent;
        t_vid    child;
        t_weight edge_cost;
        logic    reached;
        t_total  run_cost;
        logic    last;
    } t_tree_word;

    t_weight    span_weights [MAX_VERTICES][MAX_VERTICES];
    logic [5:0] vertex_count_reg;
    logic [4:0] root_reg;
    t_tree_word tree_words_due [$];
    int         mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Grows the tree from the clamped root and queues one word per non-root vertex.
    task automatic predict_tree();
        int          n;
        int          root;
        int          pick;
        int          v;
        int          rounds;
        int          final_child;
        int unsigned lowest;
        t_weight     key [MAX_VERTICES];
        bit          joined [MAX_VERTICES];
        t_vid        via [MAX_VERTICES];
        t_total      sum;
        t_tree_word  w;
        n = int'(vertex_count_reg);
        if (n < 2) n = 2;
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        if (n > ID_LIMIT) n = ID_LIMIT;
        root = int'(root_reg);
        if (root >= n) root = n - 1;
        for (v = 0; v < n; v++) begin
            key[v]    = NO_EDGE;
            joined[v] = 1'b0;
            via[v]    = '0;
        end
        key[root] = '0;
        for (rounds = 0; rounds < n; rounds++) begin
            pick   = n;
            lowest = NO_EDGE;
            // Strict compare keeps the lowest index on equal keys.
            for (v = 0; v < n; v++) begin
                if (!joined[v] && key[v] < lowest) begin
                    lowest = key[v];
                    pick   = v;
                end
            end
            if (pick == n) break;
            joined[pick] = 1'b1;
            for (v = 0; v < n; v++) begin
                if (!joined[v] && span_weights[pick][v] != NO_EDGE
                        && span_weights[pick][v] < key[v]) begin
                    key[v] = span_weights[pick][v];
                    via[v] = t_vid'(pick);
                end
            end
        end
        sum = '0;
        for (v = 0; v < n; v++) begin
            if (v != root && joined[v]) sum = sum + t_total'(key[v]);
        end
        final_child = (root == n - 1) ? n - 2 : n - 1;
        for (v = 0; v < n; v++) begin
            if (v != root) begin
                w.parent    = joined[v] ? via[v] : t_vid'(0);
                w.child     = t_vid'(v);
                w.edge_cost = joined[v] ? key[v] : NO_EDGE;
                w.reached   = joined[v];
                w.run_cost  = (v == final_child) ? sum : t_total'(0);
                w.last      = (v == final_child);
                tree_words_due.push_back(w);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_tree_word got;
        t_tree_word want;
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_VERTICES; r++) begin
                for (int c = 0; c < MAX_VERTICES; c++) span_weights[r][c] = NO_EDGE;
            end
            vertex_count_reg = NUM_VERTICES_RST;
            root_reg         = ROOT_VERTEX_RST;
            tree_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_NUM_VERTICES) begin
                    vertex_count_reg = i_cfg_data[5:0];
                end else if (i_cfg_idx == CFG_ROOT_VERTEX) begin
                    root_reg = i_cfg_data[4:0];
                end
            end
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                got = '{i_rsp.parent, i_rsp.child, i_rsp.edge_cost, i_rsp.reached,
                        i_rsp.run_cost, i_rsp.last};
                if (tree_words_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected word child %0d parent %0d cost %0d",
                                 $realtime, got.child, got.parent, got.edge_cost);
                    end
                    mismatches++;
                end else begin
                    want = tree_words_due.pop_front();
                    if (got.parent !== want.parent || got.child !== want.child
                            || got.edge_cost !== want.edge_cost
                            || got.reached !== want.reached
                            || got.run_cost !== want.run_cost
                            || got.last !== want.last) begin
                        if (mismatches < 10) begin
                            $display("%0t: word mismatch", $realtime);
                            $display("  expected parent %0d child %0d cost %0d reached %0d total %0d last %0d",
                                     want.parent, want.child, want.edge_cost, want.reached,
                                     want.run_cost, want.last);
                            $display("  actual   parent %0d child %0d cost %0d reached %0d total %0d last %0d",
                                     got.parent, got.child, got.edge_cost, got.reached,
                                     got.run_cost, got.last);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                if (i_req.op == OP_START) begin
                    predict_tree();
                end else if (int'(i_req.row) < MAX_VERTICES && int'(i_req.col) < MAX_VERTICES) begin
                    span_weights[i_req.row][i_req.col] = i_req.weight;
                end
            end
        end
        o_pending    <= tree_words_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- verif/prim_minimum_spanning_tree_top_tb.sv -----
// Top of the spanning tree engine testbench: clock, reset, matrix and start words,
// register settings and random stalls; the checker beside the block does the scoring.
// Depends on pmst_pkg, the two channel interfaces, the block and the checker.
module prim_minimum_spanning_tree_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pmst_pkg::*;

    localparam int RANDOM_WORDS = 370;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct = 9;
    int                    recv_idle_pct = 47;
    int                    words_sent = 0;

    pmst_in_if  req_ch ();
    pmst_out_if rsp_ch ();

    prim_minimum_spanning_tree_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    prim_minimum_spanning_tree_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Returns right after the edge at which the word was taken; valid stays high
    // until the next call or the next drain decides otherwise.
    task automatic send_word(input logic op, input t_vid row, input t_vid col,
                             input t_weight weight);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.op     <= op;
        req_ch.row    <= row;
        req_ch.col    <= col;
        req_ch.weight <= weight;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic start_tree();
        send_word(OP_START, t_vid'($urandom_range(31)), t_vid'($urandom_range(31)),
                  t_weight'($urandom_range(32767)));
    endtask

    // Holds the sender until every predicted word is back and the block is idle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [5:0] vertex_count, input logic [5:0] root);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NUM_VERTICES;
        i_cfg_data <= vertex_count;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ROOT_VERTEX;
        i_cfg_data <= root;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int   n_used;
        int   nv;
        int   root;
        int   style;
        int   edge_writes;
        int   pick;
        t_vid r;
        t_vid c;
        t_weight w;

        req_ch.valid  <= 1'b0;
        req_ch.op     <= OP_WRITE;
        req_ch.row    <= '0;
        req_ch.col    <= '0;
        req_ch.weight <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_NUM_VERTICES;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty matrix under the reset settings: nothing is reached.
        start_tree();
        send_word(OP_WRITE, 5'd1, 5'd2, 15'd32766);
        send_word(OP_WRITE, 5'd2, 5'd3, 15'd0);
        send_word(OP_WRITE, 5'd1, 5'd3, 15'd40);
        send_word(OP_WRITE, 5'd3, 5'd4, 15'd5);
        send_word(OP_WRITE, 5'd4, 5'd5, NO_EDGE);
        send_word(OP_WRITE, 5'd5, 5'd6, 15'd7);
        // Two equal keys out of vertex 1: the lower index has to win.
        send_word(OP_WRITE, 5'd1, 5'd5, 15'd9);
        send_word(OP_WRITE, 5'd1, 5'd6, 15'd9);
        send_word(OP_WRITE, 5'd6, 5'd7, 15'd9);
        send_word(OP_WRITE, 5'd31, 5'd0, 15'd12345);
        send_word(OP_WRITE, 5'd0, 5'd31, 15'd1);
        start_tree();
        // Too few vertices and a root beyond the last vertex.
        drain();
        set_config(6'd0, 6'd31);
        start_tree();
        // Too many vertices, saturated to the full matrix.
        drain();
        set_config(6'd63, 6'd0);
        start_tree();
        drain();
        set_config(6'd1, 6'd32);
        start_tree();
        drain();
        set_config(6'd32, 6'd31);
        start_tree();

        while (words_sent < RANDOM_WORDS) begin
            drain();
            if (words_sent < 140) begin
                send_idle_pct = 9;
                recv_idle_pct <= 47;
            end else if (words_sent < 265) begin
                send_idle_pct = 47;
                recv_idle_pct <= 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            pick = $urandom_range(99);
            if (pick < 75) nv = $urandom_range(2, 9);
            else if (pick < 85) nv = $urandom_range(32, 63);
            else if (pick < 92) nv = $urandom_range(0, 1);
            else nv = $urandom_range(0, 63);
            n_used = (nv < 2) ? 2 : ((nv > 32) ? 32 : nv);
            if ($urandom_range(99) < 75) root = $urandom_range(0, n_used - 1);
            else root = $urandom_range(0, 31);
            set_config(6'(nv), {1'($urandom_range(1)), 5'(root)});

            style = $urandom_range(2);
            edge_writes = (n_used < 12) ? $urandom_range(1, 2 * n_used + 2)
                                        : $urandom_range(10, 40);
            for (int k = 0; k < edge_writes; k++) begin
                r = ($urandom_range(99) < 90) ? t_vid'($urandom_range(n_used - 1))
                                              : t_vid'($urandom_range(31));
                c = ($urandom_range(99) < 90) ? t_vid'($urandom_range(n_used - 1))
                                              : t_vid'($urandom_range(31));
                case (style)
                    0: begin
                        w = t_weight'($urandom_range(7));
                    end
                    1: begin
                        w = t_weight'($urandom_range(32766));
                    end
                    default: begin
                        w = ($urandom_range(3) == 0) ? NO_EDGE : t_weight'($urandom_range(100));
                    end
                endcase
                send_word(OP_WRITE, r, c, w);
                if ($urandom_range(1) == 1) send_word(OP_WRITE, c, r, w);
                // A start in the middle of loading, without waiting for the set to finish.
                if ($urandom_range(99) < 4) start_tree();
            end
            start_tree();
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
